// ===== src/frc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the fragment reassembly checker.
// No dependencies; imported by every module of the block.
package frc_pkg;

    localparam int unsigned DEFAULT_STORE_BYTES = 1024;

    localparam int unsigned HDR_W   = 16;  // offset, total and length fields
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned RIDX_W  = 10;
    localparam int unsigned LIM_W   = 17;  // holds any store size up to 65536

    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned STATUS_W  = 2;

    // Action codes carried on s_tuser
    localparam logic ACT_FRAG = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Result status codes carried on m_tuser
    localparam logic [STATUS_W-1:0] ST_PROGRESS = 2'd0;
    localparam logic [STATUS_W-1:0] ST_COMPLETE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_READ     = 2'd3;

    // Result of the fragment byte taken this cycle
    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
    } frc_result_t;

endpackage

// ===== src/fragment_reassembly_checker.sv =====
`timescale 1ns / 1ps
// Top level of the fragment reassembly checker.
// Depends on frc_pkg, frc_ctrl and frc_store.
//
// Use: the slave channel carries one beat per fragment byte or per read
// request. s_tuser selects the action (0 fragment byte, 1 read), s_tlast marks
// the last byte of a fragment. The header (offset, total, length) is checked
// on the first byte of each fragment; accepted bytes go into a byte store at
// offset plus position, and a zero terminator follows a completed message.
// The master channel returns one beat for every read and for every last
// fragment byte: m_tuser gives the status, m_tdata the byte read (zero for
// fragment status beats). Beats that yield no result produce nothing.
// A result is registered first in the result stage, alongside the store
// read, and then in the output register.
// Throughput: one beat per cycle while s_tready is high. The store has a single write port, so a
// last byte that both writes data and completes the message holds s_tready
// low for the following cycle while the terminator is written.
// Reset (aresetn low, synchronous) clears assembly state and the output
// pipeline; the store contents are left as they are and need no clearing.
// When m_tready is low the output register and one further result stage
// hold; s_tready then drops until a slot frees up.
module fragment_reassembly_checker import frc_pkg::*; #(
    parameter int unsigned STORE_BYTES = DEFAULT_STORE_BYTES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [15:0] frag_offset, [31:16] message_total, [47:32] frag_length,
    // [55:48] data_byte, [65:56] read_index, [71:66] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] action
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] read_byte
    output logic [BYTE_W-1:0]    m_tdata,
    // [1:0] status
    output logic [STATUS_W-1:0]  m_tuser
);

    localparam int unsigned      AW        = $clog2(STORE_BYTES);
    localparam logic [LIM_W-1:0] STORE_LIM = LIM_W'(STORE_BYTES);

    logic [HDR_W-1:0]  frag_offset, message_total, frag_length;
    logic [BYTE_W-1:0] data_byte;
    logic [RIDX_W-1:0] read_index;
    logic [LIM_W-1:0]  read_index_ext;

    logic              s_fire, frag_fire, read_fire, read_ok;
    logic              stall;
    frc_result_t       frag_result;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [BYTE_W-1:0] rd_data;

    logic                s1_valid_reg, s1_valid_next;
    logic [STATUS_W-1:0] s1_status_reg, s1_status_next;
    logic                s1_rd_ok_reg, s1_rd_ok_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic                out_load, s1_load;

    // Unpack the beat
    assign frag_offset   = s_tdata[15:0];
    assign message_total = s_tdata[31:16];
    assign frag_length   = s_tdata[47:32];
    assign data_byte     = s_tdata[55:48];
    assign read_index    = s_tdata[65:56];

    // Output register frees when empty or taken; the result stage behind it
    // frees when it can move forward
    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !stall && (!s1_valid_reg || out_load);

    assign s_fire    = s_tvalid && s_tready;
    assign frag_fire = s_fire && (s_tuser == ACT_FRAG);
    assign read_fire = s_fire && (s_tuser == ACT_READ);

    assign read_index_ext = {{(LIM_W-RIDX_W){1'b0}}, read_index};
    assign read_ok        = read_index_ext < STORE_LIM;

    frc_ctrl #(
        .STORE_BYTES (STORE_BYTES),
        .AW          (AW)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .frag_fire        (frag_fire),
        .frag_offset      (frag_offset),
        .message_total    (message_total),
        .frag_length      (frag_length),
        .data_byte        (data_byte),
        .last_of_fragment (s_tlast),
        .result           (frag_result),
        .stall            (stall),
        .wr_en            (wr_en),
        .wr_addr          (wr_addr),
        .wr_data          (wr_data)
    );

    frc_store #(
        .STORE_BYTES (STORE_BYTES),
        .AW          (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (read_fire && read_ok),
        .rd_addr (read_index_ext[AW-1:0]),
        .rd_data (rd_data)
    );

    // Result stage: holds the result while the store read data is registered
    assign s1_load = read_fire || frag_result.valid;

    always_comb begin
        s1_valid_next  = s1_valid_reg;
        s1_status_next = s1_status_reg;
        s1_rd_ok_next  = s1_rd_ok_reg;
        if (s1_load) begin
            s1_valid_next  = 1'b1;
            s1_status_next = read_fire ? ST_READ : frag_result.status;
            s1_rd_ok_next  = read_fire && read_ok;
        end else if (out_load) begin
            s1_valid_next = 1'b0;
        end
    end

    // Output register: pick up the store byte only for an in-range read
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_byte_next   = out_byte_reg;
        if (out_load) begin
            out_valid_next  = s1_valid_reg;
            out_status_next = s1_status_reg;
            out_byte_next   = s1_rd_ok_reg ? rd_data : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_status_reg  <= s1_status_next;
        s1_rd_ok_reg   <= s1_rd_ok_next;
        out_status_reg <= out_status_next;
        out_byte_reg   <= out_byte_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_status_reg;

endmodule

// ===== src/frc_store.sv =====
`timescale 1ns / 1ps
// Payload byte store: one write port, one registered read port.
// Depends on frc_pkg.
module frc_store import frc_pkg::*; #(
    parameter int unsigned STORE_BYTES = DEFAULT_STORE_BYTES,
    parameter int unsigned AW          = $clog2(STORE_BYTES)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [STORE_BYTES];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/frc_ctrl.sv =====
`timescale 1ns / 1ps
// Header checks, assembly bookkeeping and store write port control.
// Depends on frc_pkg.
module frc_ctrl import frc_pkg::*; #(
    parameter int unsigned STORE_BYTES = DEFAULT_STORE_BYTES,
    parameter int unsigned AW          = $clog2(STORE_BYTES)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              frag_fire,
    input  logic [HDR_W-1:0]  frag_offset,
    input  logic [HDR_W-1:0]  message_total,
    input  logic [HDR_W-1:0]  frag_length,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              last_of_fragment,
    output frc_result_t       result,
    output logic              stall,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [BYTE_W-1:0] wr_data
);

    localparam logic [LIM_W-1:0] STORE_LIM = LIM_W'(STORE_BYTES);
    localparam logic [HDR_W-1:0] POS_MAX   = {HDR_W{1'b1}};

    logic             inside_reg, inside_next;
    logic             acc_reg, acc_next;
    logic             act_reg, act_next;
    logic [HDR_W-1:0] rx_reg, rx_next;
    logic [HDR_W-1:0] exp_reg, exp_next;
    logic [HDR_W-1:0] pos_reg, pos_next;
    logic [HDR_W-1:0] lo_reg, lo_next;
    logic [HDR_W-1:0] ll_reg, ll_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    pend_addr_reg, pend_addr_next;

    logic             hdr_ok, act_hdr;
    logic [HDR_W-1:0] rx_hdr, exp_hdr;
    logic             first;
    logic             acc_c, act_c;
    logic [HDR_W-1:0] rx_c, exp_c, pos_c, lo_c, ll_c;
    logic [LIM_W-1:0] data_addr, zero_addr, end_sum;
    logic [HDR_W-1:0] rx_sum;
    logic             data_wr, complete, zero_wr;

    assign first = !inside_reg;

    // Header check on the first byte of a fragment
    always_comb begin
        hdr_ok  = 1'b0;
        rx_hdr  = rx_reg;
        exp_hdr = exp_reg;
        act_hdr = act_reg;
        end_sum = {1'b0, frag_offset} + {1'b0, frag_length};
        if (frag_offset == '0) begin
            rx_hdr  = '0;
            exp_hdr = '0;
            act_hdr = 1'b0;
            if (message_total != '0 && frag_length != '0 &&
                {1'b0, message_total} < STORE_LIM && frag_length <= message_total) begin
                exp_hdr = message_total;
                act_hdr = 1'b1;
                hdr_ok  = 1'b1;
            end
        end else if (act_reg) begin
            if (frag_length == '0 || message_total != exp_reg || frag_offset != rx_reg ||
                end_sum > {1'b0, message_total}) begin
                rx_hdr  = '0;
                exp_hdr = '0;
                act_hdr = 1'b0;
            end else begin
                hdr_ok = 1'b1;
            end
        end
    end

    assign acc_c = first ? hdr_ok : acc_reg;
    assign act_c = first ? act_hdr : act_reg;
    assign rx_c  = first ? rx_hdr : rx_reg;
    assign exp_c = first ? exp_hdr : exp_reg;
    assign lo_c  = first ? frag_offset : lo_reg;
    assign ll_c  = first ? frag_length : ll_reg;
    assign pos_c = first ? '0 : pos_reg;

    assign data_addr = {1'b0, lo_c} + {1'b0, pos_c};
    assign data_wr   = frag_fire && acc_c && (pos_c < ll_c) && (data_addr < STORE_LIM);

    assign rx_sum    = rx_c + ll_c;
    assign zero_addr = {1'b0, rx_sum};
    assign complete  = frag_fire && last_of_fragment && acc_c && (rx_sum == exp_c);
    assign zero_wr   = complete && (zero_addr < STORE_LIM);

    // Write port: a deferred terminator goes first, then fragment data, then a direct terminator
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = data_addr[AW-1:0];
        wr_data = data_byte;
        if (pend_reg) begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_reg;
            wr_data = '0;
        end else if (data_wr) begin
            wr_en = 1'b1;
        end else if (zero_wr) begin
            wr_en   = 1'b1;
            wr_addr = zero_addr[AW-1:0];
            wr_data = '0;
        end
    end

    assign pend_next      = zero_wr && data_wr;
    assign pend_addr_next = zero_addr[AW-1:0];
    assign stall          = pend_reg;

    always_comb begin
        inside_next = inside_reg;
        acc_next    = acc_reg;
        act_next    = act_reg;
        rx_next     = rx_reg;
        exp_next    = exp_reg;
        pos_next    = pos_reg;
        lo_next     = lo_reg;
        ll_next     = ll_reg;
        if (frag_fire) begin
            lo_next  = lo_c;
            ll_next  = ll_c;
            exp_next = exp_c;
            act_next = complete ? 1'b0 : act_c;
            if (last_of_fragment) begin
                inside_next = 1'b0;
                pos_next    = '0;
                acc_next    = 1'b0;
                rx_next     = acc_c ? rx_sum : rx_c;
            end else begin
                inside_next = 1'b1;
                pos_next    = (pos_c == POS_MAX) ? pos_c : pos_c + 1'b1;
                acc_next    = acc_c;
                rx_next     = rx_c;
            end
        end
    end

    always_comb begin
        result.valid  = frag_fire && last_of_fragment;
        result.status = ST_PROGRESS;
        if (!acc_c) begin
            result.status = ST_REJECT;
        end else if (complete) begin
            result.status = ST_COMPLETE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_reg    <= 1'b0;
            acc_reg       <= 1'b0;
            act_reg       <= 1'b0;
            rx_reg        <= '0;
            exp_reg       <= '0;
            pos_reg       <= '0;
            lo_reg        <= '0;
            ll_reg        <= '0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
        end else begin
            inside_reg    <= inside_next;
            acc_reg       <= acc_next;
            act_reg       <= act_next;
            rx_reg        <= rx_next;
            exp_reg       <= exp_next;
            pos_reg       <= pos_next;
            lo_reg        <= lo_next;
            ll_reg        <= ll_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
        end
    end

endmodule
